FILE: hdl/dpmd_pkg.sv
// ----------------------------------------------------------------------------
// dpmd_pkg
// shared types and operation codes for the dual pipe hi/lo multiply/divide unit
// ----------------------------------------------------------------------------
package dpmd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 5;

  // operation codes; 6 and 7 are unused and leave hi/lo untouched
  typedef enum logic [2:0] {
    FUNC_MULT  = 3'd0,
    FUNC_MULTU = 3'd1,
    FUNC_DIV   = 3'd2,
    FUNC_DIVU  = 3'd3,
    FUNC_MADD  = 3'd4,
    FUNC_MADDU = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0]       func;
    logic             pipe;
    logic [WordW-1:0] rs_value;
    logic [WordW-1:0] rt_value;
    logic [RegW-1:0]  rd_index;
  } dpmd_in_t;

  typedef struct packed {
    logic [WordW-1:0] hi_word;
    logic [WordW-1:0] lo_word;
    logic             rd_write;
    logic [RegW-1:0]  rd_target;
    logic [WordW-1:0] rd_word;
  } dpmd_out_t;

  // core to top status: finished result and its family
  typedef struct packed {
    logic             done;
    logic             mul_fam;
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
  } dpmd_res_t;

endpackage

FILE: hdl/dpmd_core.sv
// ----------------------------------------------------------------------------
// dpmd_core
// iterative shift-add multiplier / restoring divider on one shared 33-bit adder
// ----------------------------------------------------------------------------
module dpmd_core import dpmd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0]       func_i,
  input  logic [WordW-1:0] rs_i,
  input  logic [WordW-1:0] rt_i,
  input  logic [WordW-1:0] acc_hi_i,
  input  logic [WordW-1:0] acc_lo_i,
  input  logic             take_i,
  output logic             idle_o,
  output dpmd_res_t        res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_ACC,
    ST_DONE
  } state_e;

  localparam int unsigned CntW = $clog2(WordW);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] hi_q, hi_d, lo_q, lo_d, b_q, b_d;
  logic             div_q, div_d, madd_q, madd_d, nop_q, nop_d;
  logic             neg_q, neg_d, rneg_q, rneg_d;

  logic             is_signed, is_div, is_madd, is_nop;
  logic [WordW-1:0] rs_mag, rt_mag;

  // shared adder
  logic [WordW:0]   add_a, add_b;
  logic [WordW+1:0] add_sum;
  logic             add_ge;

  logic [2*WordW-1:0] prod_neg, prod_acc;

  always_comb begin
    is_signed = 1'b0;
    is_div    = 1'b0;
    is_madd   = 1'b0;
    is_nop    = 1'b0;
    case (func_i)
      FUNC_MULT:  is_signed = 1'b1;
      FUNC_MULTU: is_signed = 1'b0;
      FUNC_DIV: begin
        is_signed = 1'b1;
        is_div    = 1'b1;
      end
      FUNC_DIVU:  is_div = 1'b1;
      FUNC_MADD: begin
        is_signed = 1'b1;
        is_madd   = 1'b1;
      end
      FUNC_MADDU: is_madd = 1'b1;
      default:    is_nop = 1'b1;
    endcase
    rs_mag = (is_signed && rs_i[WordW-1]) ? (WordW'(0) - rs_i) : rs_i;
    rt_mag = (is_signed && rt_i[WordW-1]) ? (WordW'(0) - rt_i) : rt_i;
  end

  // multiply: add multiplicand to hi when lo lsb set; divide: trial subtract
  always_comb begin
    if (div_q) begin
      add_a = {hi_q, lo_q[WordW-1]};
      add_b = {1'b0, b_q};
    end else begin
      add_a = {1'b0, hi_q};
      add_b = lo_q[0] ? {1'b0, b_q} : '0;
    end
    add_sum = {1'b0, add_a} + {1'b0, div_q ? ~add_b : add_b} + (WordW+2)'(div_q);
    add_ge  = add_sum[WordW+1];
  end

  assign prod_neg = (2*WordW)'(0) - {hi_q, lo_q};
  assign prod_acc = {hi_q, lo_q} + {acc_hi_i, acc_lo_i};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    b_d     = b_q;
    div_d   = div_q;
    madd_d  = madd_q;
    nop_d   = nop_q;
    neg_d   = neg_q;
    rneg_d  = rneg_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d   = '1;
          hi_d    = '0;
          lo_d    = rs_mag;
          b_d     = rt_mag;
          div_d   = is_div;
          madd_d  = is_madd;
          nop_d   = is_nop;
          neg_d   = is_signed && (rs_i[WordW-1] ^ rt_i[WordW-1]);
          rneg_d  = is_signed && rs_i[WordW-1];
          state_d = is_nop ? ST_ACC : ST_RUN;
        end
      end
      ST_RUN: begin
        if (div_q) begin
          hi_d = add_ge ? add_sum[WordW-1:0] : add_a[WordW-1:0];
          lo_d = {lo_q[WordW-2:0], add_ge};
        end else begin
          hi_d = add_sum[WordW:1];
          lo_d = {add_sum[0], lo_q[WordW-1:1]};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        // sign fixup of the magnitude result
        if (div_q) begin
          if (neg_q) begin
            lo_d = WordW'(0) - lo_q;
          end
          if (rneg_q) begin
            hi_d = WordW'(0) - hi_q;
          end
        end else if (neg_q) begin
          {hi_d, lo_d} = prod_neg;
        end
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (nop_q) begin
          hi_d = acc_hi_i;
          lo_d = acc_lo_i;
        end else if (madd_q) begin
          {hi_d, lo_d} = prod_acc;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      b_q     <= '0;
      div_q   <= 1'b0;
      madd_q  <= 1'b0;
      nop_q   <= 1'b0;
      neg_q   <= 1'b0;
      rneg_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      b_q     <= b_d;
      div_q   <= div_d;
      madd_q  <= madd_d;
      nop_q   <= nop_d;
      neg_q   <= neg_d;
      rneg_q  <= rneg_d;
    end
  end

  assign idle_o        = (state_q == ST_IDLE);
  assign res_o.done    = (state_q == ST_DONE);
  assign res_o.mul_fam = !div_q && !nop_q;
  assign res_o.hi      = hi_q;
  assign res_o.lo      = lo_q;

endmodule

FILE: hdl/dual_pipe_mult_div_hilo_unit.sv
// ----------------------------------------------------------------------------
// dual_pipe_mult_div_hilo_unit
// multiply, multiply-accumulate and divide with a hi/lo pair for each of two pipes
// ----------------------------------------------------------------------------
// multiply, madd and divide: 32 passes of the shared 33-bit adder, then sign fixup,
//   accumulate and handoff; an unused operation code skips the passes and the fixup
// the sequencer accepts no new beat until its previous result is handed off to the
//   output register;
// the next beat is taken while a finished result still waits in the output register
// reset: all hi/lo words cleared to zero, output register empty, sequencer idle
module dual_pipe_mult_div_hilo_unit import dpmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dpmd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dpmd_out_t out_data_o
);

  // hi/lo pair per pipe
  logic [WordW-1:0] hi_store_q [2];
  logic [WordW-1:0] lo_store_q [2];

  // context of the item in flight
  logic             pipe_q;
  logic [RegW-1:0]  rd_q;

  // output register
  logic             out_valid_q;
  dpmd_out_t        out_q;

  logic             core_idle;
  dpmd_res_t        core_res;
  logic             in_fire;
  logic             take;
  logic             rd_wr;

  assign in_stall_o = !core_idle;
  assign in_fire    = in_valid_i && core_idle;

  // move the finished result out when the output register is free or draining
  assign take  = core_res.done && (!out_valid_q || !out_stall_i);
  assign rd_wr = core_res.mul_fam && (rd_q != '0);

  dpmd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .func_i   (in_data_i.func),
    .rs_i     (in_data_i.rs_value),
    .rt_i     (in_data_i.rt_value),
    .acc_hi_i (hi_store_q[pipe_q]),
    .acc_lo_i (lo_store_q[pipe_q]),
    .take_i   (take),
    .idle_o   (core_idle),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_store_q[0] <= '0;
      hi_store_q[1] <= '0;
      lo_store_q[0] <= '0;
      lo_store_q[1] <= '0;
      pipe_q        <= 1'b0;
      rd_q          <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (in_fire) begin
        pipe_q <= in_data_i.pipe;
        rd_q   <= in_data_i.rd_index;
      end
      if (take) begin
        // hi/lo written back in the same edge as the result beat is loaded
        hi_store_q[pipe_q] <= core_res.hi;
        lo_store_q[pipe_q] <= core_res.lo;
        out_valid_q        <= 1'b1;
        out_q.hi_word      <= core_res.hi;
        out_q.lo_word      <= core_res.lo;
        out_q.rd_write     <= rd_wr;
        out_q.rd_target    <= rd_wr ? rd_q : '0;
        out_q.rd_word      <= rd_wr ? core_res.lo : '0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted beat keeps the sequencer busy on the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !core_idle)
    else $error("sequencer idle right after accepting a beat");

  // a handed-off result is visible as an output beat
  a_take_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (out_valid_o && out_data_o.lo_word == lo_store_q[pipe_q]
              && out_data_o.hi_word == hi_store_q[pipe_q]))
    else $error("output beat does not match stored hi/lo");

  // the rd copy is the new lo and never targets register zero
  a_rd_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rd_write) |->
      (out_data_o.rd_word == out_data_o.lo_word && out_data_o.rd_target != '0))
    else $error("bad rd copy");

  // no copy fields without a write
  a_rd_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.rd_write) |->
      (out_data_o.rd_word == '0 && out_data_o.rd_target == '0))
    else $error("rd fields set without rd write");

endmodule
